// ----- sv/sgd_weight_update_bf16_assert.svh -----
`ifndef SGD_WEIGHT_UPDATE_BF16_ASSERT_SVH
`define SGD_WEIGHT_UPDATE_BF16_ASSERT_SVH

// Same-cycle implication, checked on clk, off while reset is low.
`define SGDWU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while reset is low.
`define SGDWU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sgdwu_pkg.sv -----
package sgdwu_pkg;

	localparam logic [7:0]  EXP_MAX    = 8'hFF;
	localparam logic [7:0]  EXP_TOP    = 8'hFE;
	localparam logic [7:0]  EXP_SR_MIN = 8'd8;
	localparam logic [31:0] RNE_BIAS   = 32'h0000_7FFF;
	localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
	localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
	localparam logic [31:0] QNAN_DEF   = INF_BITS | QUIET_BIT;
	localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;

	// Sum window of the fused unit
	localparam int WIN = 78;

	// Configuration register indexes
	localparam logic [1:0] REG_LR = 2'd0;
	localparam logic [1:0] REG_L1 = 2'd1;
	localparam logic [1:0] REG_L2 = 2'd2;
	localparam logic [1:0] REG_SR = 2'd3;

	localparam int NSTAGE = 19;

	// Position of the leading one; zero input gives 0
	function automatic logic [6:0] lead_pos(input logic [WIN-1:0] m);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < WIN; i++) begin
			if (m[i]) begin
				p = 7'(i);
			end
		end
		return p;
	endfunction

	// +1.0 or -1.0 by sign for nonzero non-NaN weights, else 0
	function automatic logic [31:0] sign_of(input logic [31:0] w);
		logic [31:0] r;
		r = '0;
		if ((w[30:0] != '0) && ({1'b0, w[30:0]} <= INF_BITS)) begin
			r = {w[31], ONE_BITS[30:0]};
		end
		return r;
	endfunction

	function automatic logic [15:0] narrow_rne(input logic [31:0] x);
		logic [31:0] t;
		if ({1'b0, x[30:0]} > INF_BITS) begin
			t = x | QUIET_BIT;
		end else begin
			t = x + RNE_BIAS + {31'b0, x[16]};
		end
		return t[31:16];
	endfunction

	function automatic logic [15:0] narrow_sr(input logic [31:0] x, input logic [15:0] rnd);
		logic [7:0]  be;
		logic [15:0] r;
		logic [31:0] t;
		be = x[30:23];
		r  = x[31] ? rnd : ~rnd;
		t  = x + {16'b0, r};
		if ((be < EXP_SR_MIN) || (be > EXP_TOP)) begin
			return narrow_rne(x);
		end
		return t[31:16];
	endfunction

endpackage

// ----- sv/sgdwu_fma.sv -----
module sgdwu_fma (
	input  logic        clk,
	input  logic [5:0]  en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic        neg,
	input  logic        byp,
	output logic [31:0] res
);

	localparam int W = sgdwu_pkg::WIN;

	// stage 1: unpack, specials, product
	logic [7:0]  ea, eb, ec, ea1, eb1, ec1;
	logic        nan_a, nan_b, nan_c, az, bz, cz, sp;
	logic        spec;
	logic [31:0] sval;
	logic [23:0] ma, mb;

	logic [47:0]        mp_s1;
	logic [23:0]        mc_s1;
	logic               sp_s1, sc_s1, cz_s1, spec_s1;
	logic [31:0]        sval_s1;
	logic signed [11:0] ep_s1, ecx_s1;

	always_comb begin
		ea = a[30:23];
		eb = b[30:23];
		ec = c[30:23];
		nan_a = (ea == sgdwu_pkg::EXP_MAX) && (a[22:0] != '0);
		nan_b = (eb == sgdwu_pkg::EXP_MAX) && (b[22:0] != '0);
		nan_c = (ec == sgdwu_pkg::EXP_MAX) && (c[22:0] != '0);
		az = (a[30:0] == '0);
		bz = (b[30:0] == '0);
		cz = (c[30:0] == '0);
		sp = a[31] ^ b[31] ^ neg;
		ea1 = (ea == '0) ? 8'd1 : ea;
		eb1 = (eb == '0) ? 8'd1 : eb;
		ec1 = (ec == '0) ? 8'd1 : ec;
		ma = {(ea != '0), a[22:0]};
		mb = {(eb != '0), b[22:0]};
		spec = 1'b1;
		sval = c;
		if (byp) begin
			sval = c;
		end else if (nan_a) begin
			sval = a | sgdwu_pkg::QUIET_BIT;
		end else if (nan_b) begin
			sval = b | sgdwu_pkg::QUIET_BIT;
		end else if (nan_c) begin
			sval = c | sgdwu_pkg::QUIET_BIT;
		end else if ((ea == sgdwu_pkg::EXP_MAX) || (eb == sgdwu_pkg::EXP_MAX)) begin
			if (az || bz) begin
				sval = sgdwu_pkg::QNAN_DEF;
			end else if ((ec == sgdwu_pkg::EXP_MAX) && (c[31] != sp)) begin
				sval = sgdwu_pkg::QNAN_DEF;
			end else begin
				sval = {sp, sgdwu_pkg::INF_BITS[30:0]};
			end
		end else if (ec == sgdwu_pkg::EXP_MAX) begin
			sval = c;
		end else if (az || bz) begin
			sval = cz ? {sp & c[31], 31'b0} : c;
		end else begin
			spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mp_s1   <= ma * mb;
			mc_s1   <= {(ec != '0), c[22:0]};
			sp_s1   <= sp;
			sc_s1   <= c[31];
			cz_s1   <= cz;
			spec_s1 <= spec;
			sval_s1 <= sval;
			ep_s1   <= 12'(ea1) + 12'(eb1) - 12'd300;
			ecx_s1  <= 12'(ec1) - 12'd150;
		end
	end

	// stage 2: align addend against the product
	logic signed [11:0] diff, rs, e0;
	logic               clamp;
	logic [6:0]         rs7;
	logic [2*W-1:0]     csh;

	logic [W-1:0]       pw_s2, cw_s2;
	logic signed [11:0] e0_s2;
	logic               sp_s2, sc_s2, spec_s2;
	logic [31:0]        sval_s2;

	always_comb begin
		diff  = ecx_s1 - ep_s1;
		clamp = !cz_s1 && (diff > 12'sd50);
		rs    = 12'sd50 - diff;
		if (clamp) begin
			rs7 = '0;
		end else if (cz_s1 || (rs > 12'sd127)) begin
			rs7 = 7'd127;
		end else begin
			rs7 = rs[6:0];
		end
		e0  = clamp ? (ecx_s1 - 12'sd53) : (ep_s1 - 12'sd3);
		csh = {1'b0, mc_s1, 53'b0, {W{1'b0}}} >> rs7;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pw_s2   <= clamp ? W'(1) : {27'b0, mp_s1, 3'b0};
			cw_s2   <= csh[2*W-1:W] | {{(W-1){1'b0}}, |csh[W-1:0]};
			e0_s2   <= e0;
			sp_s2   <= sp_s1;
			sc_s2   <= sc_s1;
			spec_s2 <= spec_s1;
			sval_s2 <= sval_s1;
		end
	end

	// stage 3: add or subtract magnitudes
	logic [W:0]   d1;
	logic [W-1:0] m_sum, m_d2;

	logic [W-1:0]       m_s3;
	logic               s_s3, spec_s3;
	logic signed [11:0] e0_s3;
	logic [31:0]        sval_s3;

	always_comb begin
		m_sum = pw_s2 + cw_s2;
		d1    = {1'b0, pw_s2} - {1'b0, cw_s2};
		m_d2  = cw_s2 - pw_s2;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			if (sp_s2 == sc_s2) begin
				m_s3 <= m_sum;
				s_s3 <= sp_s2;
			end else if (d1[W]) begin
				m_s3 <= m_d2;
				s_s3 <= sc_s2;
			end else begin
				m_s3 <= d1[W-1:0];
				s_s3 <= sp_s2;
			end
			e0_s3   <= e0_s2;
			spec_s3 <= spec_s2;
			sval_s3 <= sval_s2;
		end
	end

	// stage 4: leading one, exponent, shift amount
	logic [6:0]         lp;
	logic signed [11:0] ex, q, tq;
	logic               nrm;

	logic [W-1:0]       m_s4;
	logic [6:0]         t_s4;
	logic               nrm_s4, zero_s4, s_s4, spec_s4;
	logic [11:0]        eb_s4;
	logic [31:0]        sval_s4;

	always_comb begin
		lp  = sgdwu_pkg::lead_pos(m_s3);
		ex  = 12'(lp) + e0_s3 + 12'sd127;
		nrm = (ex > 12'sd0);
		q   = nrm ? (12'(lp) - 12'sd23) : (-12'sd149 - e0_s3);
		if (q > 12'sd78) begin
			q = 12'sd78;
		end
		tq = q + 12'sd23;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			m_s4    <= m_s3;
			t_s4    <= tq[6:0];
			nrm_s4  <= nrm;
			zero_s4 <= (m_s3 == '0);
			eb_s4   <= ex - 12'sd1;
			s_s4    <= s_s3;
			spec_s4 <= spec_s3;
			sval_s4 <= sval_s3;
		end
	end

	// stage 5: shift into place, round decision
	logic [W+25:0] z, r;
	logic          lost, stk;

	logic [23:0]   kept_s5;
	logic          inc_s5, nrm_s5, zero_s5, s_s5, spec_s5;
	logic [11:0]   eb_s5;
	logic [31:0]   sval_s5;

	always_comb begin
		z    = {m_s4, 26'b0};
		r    = z >> t_s4;
		lost = |(z & ~({(W+26){1'b1}} << t_s4));
		stk  = r[1] | r[0] | lost;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			kept_s5 <= r[26:3];
			inc_s5  <= r[2] & (stk | r[3]);
			nrm_s5  <= nrm_s4;
			zero_s5 <= zero_s4;
			eb_s5   <= eb_s4;
			s_s5    <= s_s4;
			spec_s5 <= spec_s4;
			sval_s5 <= sval_s4;
		end
	end

	// stage 6: pack with overflow to infinity
	logic [35:0] base, sum;
	logic [30:0] mag;

	always_comb begin
		base = nrm_s5 ? (({24'b0, eb_s5} << 23) + 36'(kept_s5)) : 36'(kept_s5);
		sum  = base + 36'(inc_s5);
		mag  = (sum >= 36'(sgdwu_pkg::INF_BITS)) ? sgdwu_pkg::INF_BITS[30:0] : sum[30:0];
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			if (spec_s5) begin
				res <= sval_s5;
			end else if (zero_s5) begin
				res <= '0;
			end else begin
				res <= {s_s5, mag};
			end
		end
	end

endmodule

// ----- sv/sgd_weight_update_bf16.sv -----
// SGD update of one bf16 weight per item, with optional L1/L2 penalty.
// Item channel: item_valid / item_stall with weight_in, gradient,
// random_bits and last_element; an item is taken when valid is high and
// stall is low. Result channel: result_valid / result_stall with
// weight_out and last_out, held steady while stalled.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 learning rate, 1 L1 lambda, 2 L2 lambda, 3 stochastic enable.
// cfg_ready is always high. Write registers only while the pipeline is empty.
// Nineteen register stages: three fused fp32 multiply-add units of six
// stages each (L2 term, L1 term, step) and one narrowing stage. result_valid
// is the valid bit of the narrowing stage, the last one. One item per cycle
// is taken when the output flows.
// Each stage has its own valid bit and moves when its successor is free,
// so a stalled receiver only backs up the pipeline once bubbles are
// filled; item_stall rises when stage one cannot move.
// Reset clears all valid bits and sets the configuration registers to zero.
`include "sgd_weight_update_bf16_assert.svh"

module sgd_weight_update_bf16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [15:0] weight_in,
	input  logic [31:0] gradient,
	input  logic [15:0] random_bits,
	input  logic        last_element,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] weight_out,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NS = sgdwu_pkg::NSTAGE;

	logic [31:0] lr_q, l1_q, l2_q;
	logic        sr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= '0;
			l1_q <= '0;
			l2_q <= '0;
			sr_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sgdwu_pkg::REG_LR: lr_q <= cfg_data;
				sgdwu_pkg::REG_L1: l1_q <= cfg_data;
				sgdwu_pkg::REG_L2: l2_q <= cfg_data;
				sgdwu_pkg::REG_SR: sr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage valid bits and per-stage advance
	logic [NS:1]   vld_s;
	logic [NS+1:1] en;

	assign en[NS+1] = ~result_stall;

	genvar k;
	generate
		for (k = 1; k <= NS; k++) begin : g_en
			assign en[k] = ~vld_s[k] | en[k+1];
		end
	endgenerate

	assign item_stall   = ~en[1];
	assign result_valid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= item_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// side data that travels with each item
	logic [15:0] wgt_s [1:NS-1];
	logic [15:0] rnd_s [1:NS-1];
	logic        lst_s [1:NS-1];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			wgt_s[1] <= weight_in;
			rnd_s[1] <= random_bits;
			lst_s[1] <= last_element;
		end
		for (int i = 2; i <= NS-1; i++) begin
			if (en[i]) begin
				wgt_s[i] <= wgt_s[i-1];
				rnd_s[i] <= rnd_s[i-1];
				lst_s[i] <= lst_s[i-1];
			end
		end
	end

	logic [31:0] g1, g2, wn;
	logic [31:0] w6, w12;

	assign w6  = {wgt_s[6], 16'b0};
	assign w12 = {wgt_s[12], 16'b0};

	// g = l2 * w + grad
	sgdwu_fma u_fma_l2 (
		.clk (clk),
		.en  (en[6:1]),
		.a   (l2_q),
		.b   ({weight_in, 16'b0}),
		.c   (gradient),
		.neg (1'b0),
		.byp (l2_q[30:0] == '0),
		.res (g1)
	);

	// g = l1 * sign(w) + g
	sgdwu_fma u_fma_l1 (
		.clk (clk),
		.en  (en[12:7]),
		.a   (l1_q),
		.b   (sgdwu_pkg::sign_of(w6)),
		.c   (g1),
		.neg (1'b0),
		.byp (l1_q[30:0] == '0),
		.res (g2)
	);

	// w = w - lr * g
	sgdwu_fma u_fma_step (
		.clk (clk),
		.en  (en[18:13]),
		.a   (lr_q),
		.b   (g2),
		.c   (w12),
		.neg (1'b1),
		.byp (1'b0),
		.res (wn)
	);

	logic [15:0] wout_s19;
	logic        last_s19;

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			wout_s19 <= sr_q ? sgdwu_pkg::narrow_sr(wn, rnd_s[NS-1])
			                 : sgdwu_pkg::narrow_rne(wn);
			last_s19 <= lst_s[NS-1];
		end
	end

	assign weight_out = wout_s19;
	assign last_out   = last_s19;

	`SGDWU_ASSERT_NOW(a_flow_free, (!result_valid || !result_stall), !item_stall, "stall with free output")
	`SGDWU_ASSERT_NEXT(a_accept_lands, (item_valid && !item_stall), vld_s[1], "accepted item lost at entry")
	`SGDWU_ASSERT_NOW(a_full_stall, ((&vld_s) && result_stall), item_stall, "full pipeline took an item")

endmodule
